FILE: design/irdl_pkg.sv
// shared types and constants for the ir distance linearizer
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package irdl_pkg;

	// operation codes
	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_RESET = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	// shared multiplier operand and product widths
	localparam int MUL_A_W = 23;
	localparam int MUL_B_W = 22;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// reciprocal shift: q = (z * m) >> RECIP_SHIFT is exact for the operand ranges used
	localparam int RECIP_SHIFT = 25;
	localparam logic [MUL_B_W-1:0] RECIP_10 = 22'd3355444;

	// voltage scale used for threshold tests, hundredths of a volt
	localparam logic [MUL_B_W-1:0] VOLT_PCT = 22'd100;

	// clamp limits on v in units of 2^-16 V
	localparam logic signed [19:0] V_CLAMP_NEAR = 20'sd124519; // 1.9 V and above
	localparam logic signed [19:0] V_CLAMP_FAR  = 20'sd19660;  // 0.3 V and below

	// clamped distances, cm Q8.8
	localparam logic [15:0] D_NEAR = 16'd2560;
	localparam logic [15:0] D_FAR  = 16'd38400;

	localparam int SEG_N = 5;
	typedef logic [2:0] seg_idx_t;

	// lower segment edges on v (segments 0 to 3; segment 4 takes the rest)
	localparam logic [16:0] SEG_VMIN [SEG_N-1] = '{17'd72090, 17'd49152, 17'd39322, 17'd26215};
	// lower edge voltage in hundredths times 65536
	localparam logic [23:0] SEG_VLO [SEG_N] =
		'{24'd7208960, 24'd4915200, 24'd3932160, 24'd2621440, 24'd1966080};
	// distance drop across the segment, cm
	localparam logic [MUL_B_W-1:0] SEG_DD [SEG_N] = '{22'd10, 22'd10, 22'd20, 22'd50, 22'd50};
	// rounding term 128 * width
	localparam logic [25:0] SEG_HALF [SEG_N] = '{26'd10240, 26'd4480, 26'd1920, 26'd2560, 26'd1280};
	// reciprocal of segment width in hundredths, scaled by 2^25
	localparam logic [MUL_B_W-1:0] SEG_RECIP [SEG_N] =
		'{22'd419431, 22'd958699, 22'd2236963, 22'd1677722, 22'd3355444};
	// distance at the lower edge, cm Q8.8
	localparam logic [15:0] SEG_DA [SEG_N] = '{16'd5120, 16'd7680, 16'd12800, 16'd25600, 16'd38400};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_VOLT,
		ST_SEG,
		ST_DV,
		ST_DIVW,
		ST_DIST,
		ST_UPD
	} st_t;

	// request to the shared multiplier
	typedef struct packed {
		logic               en;
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mul_req_t;

	// update request to the last/min/max tracker
	typedef struct packed {
		logic        en;
		logic        set_all;
		logic [15:0] dist_cm;
	} upd_t;

endpackage

FILE: design/irdl_mul.sv
// shared unsigned multiplier with registered product
// depends on irdl_pkg for the request type and widths
`timescale 1ns / 1ps

module irdl_mul (
	input  logic                          clk,
	input  irdl_pkg::mul_req_t            req,
	output logic [irdl_pkg::MUL_P_W-1:0]  prod
);

	logic [irdl_pkg::MUL_P_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= irdl_pkg::MUL_P_W'(req.a) * irdl_pkg::MUL_P_W'(req.b);
		end
	end

	assign prod = prod_q;

endmodule

FILE: design/irdl_track.sv
// last, minimum and maximum distance hold
// depends on irdl_pkg for the update request type
`timescale 1ns / 1ps

module irdl_track (
	input  logic            clk,
	input  logic            arst_n,
	input  irdl_pkg::upd_t  upd,
	output logic [15:0]     last_dist,
	output logic [15:0]     min_dist,
	output logic [15:0]     max_dist
);

	logic        have_q;
	logic [15:0] last_q;
	logic [15:0] min_q;
	logic [15:0] max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
			last_q <= '0;
			min_q  <= '0;
			max_q  <= '0;
		end else if (upd.en) begin
			have_q <= 1'b1;
			last_q <= upd.dist_cm;
			// first sample or explicit reset seeds both extremes
			if (upd.set_all || !have_q) begin
				min_q <= upd.dist_cm;
				max_q <= upd.dist_cm;
			end else begin
				if (upd.dist_cm < min_q) begin
					min_q <= upd.dist_cm;
				end
				if (upd.dist_cm > max_q) begin
					max_q <= upd.dist_cm;
				end
			end
		end
	end

	assign last_dist = last_q;
	assign min_dist  = min_q;
	assign max_dist  = max_q;

`ifndef SYNTHESIS
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		have_q |-> (min_q <= last_q && last_q <= max_q))
		else $error("tracker order broken");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!have_q |-> (last_q == 16'd0 && min_q == 16'd0 && max_q == 16'd0))
		else $error("tracker not clear before first sample");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		have_q |-> (min_q >= irdl_pkg::D_NEAR && max_q <= irdl_pkg::D_FAR))
		else $error("tracked distance out of range");
`endif

endmodule

FILE: design/ir_distance_linearizer_minmax_top.sv
// top level of the ir distance linearizer with last/min/max hold
// depends on irdl_pkg, irdl_mul and irdl_track
`timescale 1ns / 1ps

// a read or reset item passes from acceptance through the states volt, seg, dv, divw
//   and dist to upd, a query item goes straight to upd; upd holds while the previous
//   result still waits for out_ready, and result valid is registered from upd. The single
//   shared multiplier is used four times per sample (scale, x100, slope,
//   reciprocal of segment width); the next item is accepted only once back in idle
// reset: arst_n clears sequencer, result valid, calibration offset and the held
//   distances to zero

module ir_distance_linearizer_minmax_top #(
	parameter int ADC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,

	// configuration
	input  logic               cfg_wr_en,
	input  logic signed [18:0] calibration_offset,

	// input items
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         operation,
	input  logic [15:0]        raw_sample,

	// result items
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        distance,
	output logic [15:0]        min_distance,
	output logic [15:0]        max_distance
);

	localparam int          SAMPLE_SHIFT = 16 - ADC_BITS;
	localparam logic [15:0] SAMPLE_MASK  = 16'((32'd1 << ADC_BITS) - 32'd1);
	localparam int          AW           = irdl_pkg::MUL_A_W;
	localparam int          PW           = irdl_pkg::MUL_P_W;
	localparam int          RS           = irdl_pkg::RECIP_SHIFT;

	irdl_pkg::st_t      st_q, st_d;
	irdl_pkg::mul_req_t mul_req;
	irdl_pkg::upd_t     upd;

	logic [PW-1:0]      prod;
	logic signed [18:0] cal_q;
	logic               out_valid_q;
	logic               upd_go;

	// datapath registers
	logic [1:0]           op_q;
	logic signed [19:0]   v_q;
	irdl_pkg::seg_idx_t   seg_q;
	logic                 near_q;
	logic                 far_q;
	logic [15:0]          dist_q;

	// combinational datapath
	logic [15:0]          samp;
	logic [21:0]          x33;
	logic                 in_is_sample;
	logic                 op_is_sample;
	logic signed [19:0]   v_d;
	irdl_pkg::seg_idx_t   seg_d;
	logic [22:0]          dv;
	logic [25:0]          y;
	logic [15:0]          dist_d;

	// sample aligned to 16 bits, then times 33 by shift and add
	assign samp         = 16'((raw_sample & SAMPLE_MASK) << SAMPLE_SHIFT);
	assign x33          = 22'({samp, 5'b0}) + 22'(samp);
	assign in_is_sample = operation inside {irdl_pkg::OP_READ, irdl_pkg::OP_RESET};
	assign op_is_sample = op_q inside {irdl_pkg::OP_READ, irdl_pkg::OP_RESET};

	// volts in 2^-16 units: floor(33*s/10) plus offset
	assign v_d = $signed({2'b00, prod[RS+17:RS]}) + $signed({cal_q[18], cal_q});

	// segment pick; only meaningful when no clamp applies
	always_comb begin
		if (v_q[16:0] >= irdl_pkg::SEG_VMIN[0]) begin
			seg_d = 3'd0;
		end else if (v_q[16:0] >= irdl_pkg::SEG_VMIN[1]) begin
			seg_d = 3'd1;
		end else if (v_q[16:0] >= irdl_pkg::SEG_VMIN[2]) begin
			seg_d = 3'd2;
		end else if (v_q[16:0] >= irdl_pkg::SEG_VMIN[3]) begin
			seg_d = 3'd3;
		end else begin
			seg_d = 3'd4;
		end
	end

	// offset into the segment: 100*v minus lower edge
	assign dv = 23'(prod[23:0] - irdl_pkg::SEG_VLO[seg_q]);
	// slope product plus half a step for round to nearest
	assign y  = prod[25:0] + irdl_pkg::SEG_HALF[seg_q];

	always_comb begin
		if (near_q) begin
			dist_d = irdl_pkg::D_NEAR;
		end else if (far_q) begin
			dist_d = irdl_pkg::D_FAR;
		end else begin
			dist_d = irdl_pkg::SEG_DA[seg_q] - 16'(prod[RS+14:RS]);
		end
	end

	// calibration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_wr_en) begin
			cal_q <= calibration_offset;
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= irdl_pkg::ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// next state and multiplier operand selection
	always_comb begin
		st_d        = st_q;
		mul_req.en  = 1'b0;
		mul_req.a   = '0;
		mul_req.b   = '0;
		upd_go      = 1'b0;
		case (st_q)
			irdl_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (in_is_sample) begin
						mul_req.en = 1'b1;
						mul_req.a  = AW'(x33);
						mul_req.b  = irdl_pkg::RECIP_10;
						st_d       = irdl_pkg::ST_VOLT;
					end else begin
						st_d = irdl_pkg::ST_UPD;
					end
				end
			end
			irdl_pkg::ST_VOLT: begin
				st_d = irdl_pkg::ST_SEG;
			end
			irdl_pkg::ST_SEG: begin
				mul_req.en = 1'b1;
				mul_req.a  = AW'(v_q[16:0]);
				mul_req.b  = irdl_pkg::VOLT_PCT;
				st_d       = irdl_pkg::ST_DV;
			end
			irdl_pkg::ST_DV: begin
				mul_req.en = 1'b1;
				mul_req.a  = dv;
				mul_req.b  = irdl_pkg::SEG_DD[seg_q];
				st_d       = irdl_pkg::ST_DIVW;
			end
			irdl_pkg::ST_DIVW: begin
				// divide by the segment width through its reciprocal
				mul_req.en = 1'b1;
				mul_req.a  = AW'(y[25:8]);
				mul_req.b  = irdl_pkg::SEG_RECIP[seg_q];
				st_d       = irdl_pkg::ST_DIST;
			end
			irdl_pkg::ST_DIST: begin
				st_d = irdl_pkg::ST_UPD;
			end
			irdl_pkg::ST_UPD: begin
				// hold while the previous result is still waiting
				if (!out_valid_q || out_ready) begin
					upd_go = 1'b1;
					st_d   = irdl_pkg::ST_IDLE;
				end
			end
			default: begin
				st_d = irdl_pkg::ST_IDLE;
			end
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (st_q == irdl_pkg::ST_IDLE && in_valid) begin
			op_q <= operation;
		end
		if (st_q == irdl_pkg::ST_VOLT) begin
			v_q <= v_d;
		end
		if (st_q == irdl_pkg::ST_SEG) begin
			seg_q  <= seg_d;
			near_q <= (v_q >= irdl_pkg::V_CLAMP_NEAR);
			far_q  <= (v_q <= irdl_pkg::V_CLAMP_FAR);
		end
		if (st_q == irdl_pkg::ST_DIST) begin
			dist_q <= dist_d;
		end
	end

	// result valid; the held distances themselves serve as the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign upd.en      = upd_go && op_is_sample;
	assign upd.set_all = (op_q == irdl_pkg::OP_RESET);
	assign upd.dist_cm = dist_q;

	irdl_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (prod)
	);

	irdl_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (upd),
		.last_dist (distance),
		.min_dist  (min_distance),
		.max_dist  (max_distance)
	);

	assign in_ready  = (st_q == irdl_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_sample_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready &&
		 (operation == irdl_pkg::OP_READ || operation == irdl_pkg::OP_RESET))
		|=> st_q == irdl_pkg::ST_VOLT)
		else $error("sample item did not start conversion");

	a_upd_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == irdl_pkg::ST_UPD && out_valid_q && !out_ready) |=> st_q == irdl_pkg::ST_UPD)
		else $error("update overran a pending result");

	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == irdl_pkg::ST_UPD && op_is_sample)
		|-> (dist_q >= irdl_pkg::D_NEAR && dist_q <= irdl_pkg::D_FAR))
		else $error("converted distance out of range");
`endif

endmodule
